// ===== design/pidf_pkg.sv =====
// pidf_pkg: shared constants, register codes, config and flow-control types
// for the PIDF control step unit. Depends on nothing.
package pidf_pkg;

	// Fixed divisors of the integrator increment and of the final sum.
	localparam int unsigned I_DIVISOR   = 100;
	localparam int unsigned OUT_DIVISOR = 100;

	// Constant divider: |dividend| < 2^MAG_W, q = (mag * RECIP) >> SHIFT.
	// RECIP = ceil(2^SHIFT / D) with SHIFT = MAG_W + clog2(D) gives exact floors.
	localparam int unsigned MAG_W   = 34;
	localparam int unsigned HALF_W  = MAG_W / 2;
	localparam int unsigned RECIP_W = MAG_W + 1;
	localparam int unsigned PP_W    = (MAG_W - HALF_W) + RECIP_W;
	localparam int unsigned PROD_W  = MAG_W + RECIP_W;
	localparam int unsigned SHIFT_W = 6;

	localparam int unsigned I_SHIFT   = MAG_W + $clog2(I_DIVISOR);
	localparam int unsigned OUT_SHIFT = MAG_W + $clog2(OUT_DIVISOR);

	localparam logic [63:0] I_RECIP_64 =
		((64'd1 << I_SHIFT) + 64'(I_DIVISOR) - 64'd1) / 64'(I_DIVISOR);
	localparam logic [63:0] OUT_RECIP_64 =
		((64'd1 << OUT_SHIFT) + 64'(OUT_DIVISOR) - 64'd1) / 64'(OUT_DIVISOR);

	localparam logic [RECIP_W-1:0] I_RECIP   = I_RECIP_64[RECIP_W-1:0];
	localparam logic [RECIP_W-1:0] OUT_RECIP = OUT_RECIP_64[RECIP_W-1:0];
	localparam logic [SHIFT_W-1:0] I_SHIFT_V   = SHIFT_W'(I_SHIFT);
	localparam logic [SHIFT_W-1:0] OUT_SHIFT_V = SHIFT_W'(OUT_SHIFT);

	// Pipeline depth, input register through result register.
	localparam int unsigned NSTAGE = 8;

	// Config port.
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned LIMIT_W    = 31;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_GAIN_FF      = 3'd3,
		REG_WINDUP_LIMIT = 3'd4,
		REG_DERIV_LIMIT  = 3'd5,
		REG_OUTPUT_LIMIT = 3'd6
	} reg_idx_t;

	typedef enum logic {
		CMD_RUN   = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [GAIN_W-1:0]  gain_ff;
		logic [LIMIT_W-1:0] windup_limit;
		logic [LIMIT_W-1:0] deriv_limit;
		logic [LIMIT_W-1:0] output_limit;
	} cfg_t;

	// fill: an item actually enters the stage this cycle.
	typedef struct packed {
		logic [NSTAGE-1:0] fill;
	} flow_t;

endpackage

// ===== design/pidf_control_step_unit.sv =====
// PIDF control step unit: P, clamped I and D, and setpoint feedforward per item.
// Pipeline: 8 register stages, s1 through s8, from the item register to the result register.
// Throughput: one item per cycle unless a low result_ready stalls the 8-stage pipeline;
//   the integrator add-and-clamp is one stage, so back-to-back items see each other's state.
// Reset (arst_n low): pipeline empty, integrator/last error/held terms zero,
//   gains and windup/deriv limits zero, output limit 2^31-1.
module pidf_control_step_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// update items
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             cmd,
	input  logic signed [15:0]               set_point,
	input  logic signed [15:0]               measured,
	// results
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic signed [31:0]               drive,
	output logic signed [16:0]               error_out,
	output logic signed [32:0]               p_term_out,
	output logic signed [31:0]               i_term_out,
	output logic signed [31:0]               d_term_out,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pidf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [pidf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pidf_pkg::cfg_t  cfg;
	pidf_pkg::flow_t flow;

	pidf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidf_flow u_flow (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.flow         (flow)
	);

	// ------------------------------------------------------------------
	// Control state. Each piece updates when the owning stage takes an item (last error and
	// held terms on run items only), so state always reflects the item just ahead in program order.
	// ------------------------------------------------------------------
	logic signed [16:0] last_err_q;   // error of the last run item (stage 1 -> 2)
	logic signed [31:0] integrator_q; // integrator after clamp (stage 4 -> 5)
	logic signed [16:0] err_hold_q;   // terms of the last run item, shown on clears
	logic signed [32:0] p_hold_q;
	logic signed [31:0] d_hold_q;

	// ------------------------------------------------------------------
	// Pipeline registers
	// ------------------------------------------------------------------
	// s1: raw item
	pidf_pkg::cmd_t     cmd_s1;
	logic signed [15:0] sp_s1;
	logic signed [15:0] meas_s1;
	// s2: error and the four products
	pidf_pkg::cmd_t     cmd_s2;
	logic signed [16:0] err_s2;
	logic signed [32:0] p_s2;
	logic signed [33:0] d_s2;
	logic signed [31:0] ff_s2;
	logic [31:0]        imag_s2;
	logic               ineg_s2;
	// s3: derivative clamped, integrator increment partial products in u_idiv
	pidf_pkg::cmd_t     cmd_s3;
	logic signed [16:0] err_s3;
	logic signed [32:0] p_s3;
	logic signed [31:0] d_s3;
	logic signed [31:0] ff_s3;
	logic               ineg_s3;
	// s4: signed increment
	pidf_pkg::cmd_t     cmd_s4;
	logic signed [16:0] err_s4;
	logic signed [32:0] p_s4;
	logic signed [31:0] d_s4;
	logic signed [31:0] ff_s4;
	logic signed [32:0] inc_s4;
	// s5: integrator updated (held in integrator_q), clear items pick held terms
	pidf_pkg::cmd_t     cmd_s5;
	logic signed [16:0] err_s5;
	logic signed [32:0] p_s5;
	logic signed [31:0] d_s5;
	logic signed [31:0] ff_s5;
	// s6: magnitude and sign of the sum
	pidf_pkg::cmd_t     cmd_s6;
	logic signed [16:0] err_s6;
	logic signed [32:0] p_s6;
	logic signed [31:0] i_s6;
	logic signed [31:0] d_s6;
	logic [pidf_pkg::MAG_W-1:0] smag_s6;
	logic               sneg_s6;
	// s7: output divide partial products in u_odiv
	pidf_pkg::cmd_t     cmd_s7;
	logic signed [16:0] err_s7;
	logic signed [32:0] p_s7;
	logic signed [31:0] i_s7;
	logic signed [31:0] d_s7;
	logic               sneg_s7;
	// s8: result register
	logic signed [31:0] drive_s8;
	logic signed [16:0] err_s8;
	logic signed [32:0] p_s8;
	logic signed [31:0] i_s8;
	logic signed [31:0] d_s8;

	// ------------------------------------------------------------------
	// s1 -> s2: error, error change and products
	// ------------------------------------------------------------------
	logic signed [16:0] err_c1;
	logic signed [16:0] err_neg_c1;
	logic [15:0]        err_mag_c1;
	logic signed [17:0] derr_c1;
	logic signed [33:0] p_full_c1;
	logic signed [34:0] d_full_c1;
	logic signed [32:0] ff_full_c1;
	logic [31:0]        imag_c1;

	assign err_c1     = 17'(sp_s1) - 17'(meas_s1);
	assign err_neg_c1 = -err_c1;
	// error never reaches -2^16, so the magnitude fits 16 bits
	assign err_mag_c1 = err_c1[16] ? err_neg_c1[15:0] : err_c1[15:0];
	assign derr_c1    = 18'(err_c1) - 18'(last_err_q);
	assign p_full_c1  = 34'(err_c1) * 34'($signed({1'b0, cfg.gain_p}));
	assign d_full_c1  = 35'(derr_c1) * 35'($signed({1'b0, cfg.gain_d}));
	assign ff_full_c1 = 33'(sp_s1) * 33'($signed({1'b0, cfg.gain_ff}));
	assign imag_c1    = 32'(err_mag_c1) * 32'(cfg.gain_i);

	// ------------------------------------------------------------------
	// s2 -> s3: derivative clamp, integrator increment divide (first half)
	// ------------------------------------------------------------------
	logic signed [33:0] dlim_c2;
	logic signed [33:0] dclamp_c2;

	assign dlim_c2 = $signed({3'b000, cfg.deriv_limit});

	always_comb begin
		if (d_s2 > dlim_c2) begin
			dclamp_c2 = dlim_c2;
		end else if (d_s2 < -dlim_c2) begin
			dclamp_c2 = -dlim_c2;
		end else begin
			dclamp_c2 = d_s2;
		end
	end

	logic [pidf_pkg::MAG_W-1:0] iquot;

	pidf_cdiv u_idiv (
		.clk   (clk),
		.en    (flow.fill[2]),
		.mag   (pidf_pkg::MAG_W'(imag_s2)),
		.recip (pidf_pkg::I_RECIP),
		.shift (pidf_pkg::I_SHIFT_V),
		.quot  (iquot)
	);

	// ------------------------------------------------------------------
	// s3 -> s4: restore sign of the increment (truncation toward zero)
	// ------------------------------------------------------------------
	logic signed [32:0] iq_c3;
	logic signed [32:0] inc_c3;

	assign iq_c3  = $signed({1'b0, iquot[31:0]});
	assign inc_c3 = ineg_s3 ? -iq_c3 : iq_c3;

	// ------------------------------------------------------------------
	// s4 -> s5: integrator add and windup clamp; clear zeroes it
	// ------------------------------------------------------------------
	logic signed [33:0] isum_c4;
	logic signed [33:0] wlim_c4;
	logic signed [33:0] iclamp_c4;
	logic signed [31:0] integ_next_c4;
	logic               run_c4;

	assign isum_c4 = 34'(integrator_q) + 34'(inc_s4);
	assign wlim_c4 = $signed({3'b000, cfg.windup_limit});
	assign run_c4  = (cmd_s4 == pidf_pkg::CMD_RUN);

	always_comb begin
		if (isum_c4 > wlim_c4) begin
			iclamp_c4 = wlim_c4;
		end else if (isum_c4 < -wlim_c4) begin
			iclamp_c4 = -wlim_c4;
		end else begin
			iclamp_c4 = isum_c4;
		end
	end

	assign integ_next_c4 = run_c4 ? iclamp_c4[31:0] : '0;

	// ------------------------------------------------------------------
	// s5 -> s6: four-term sum, split into sign and magnitude
	// ------------------------------------------------------------------
	logic signed [34:0] sum_c5;
	logic signed [34:0] sum_neg_c5;

	assign sum_c5     = 35'(p_s5) + 35'(integrator_q) + 35'(d_s5) + 35'(ff_s5);
	assign sum_neg_c5 = -sum_c5;

	// ------------------------------------------------------------------
	// s6 -> s7 -> s8: output divide, saturate, sign
	// ------------------------------------------------------------------
	logic [pidf_pkg::MAG_W-1:0] oquot;

	pidf_cdiv u_odiv (
		.clk   (clk),
		.en    (flow.fill[6]),
		.mag   (smag_s6),
		.recip (pidf_pkg::OUT_RECIP),
		.shift (pidf_pkg::OUT_SHIFT_V),
		.quot  (oquot)
	);

	logic [pidf_pkg::MAG_W-1:0]   olim_c7;
	logic [pidf_pkg::LIMIT_W-1:0] osat_c7;
	logic signed [31:0]           dpos_c7;
	logic signed [31:0]           drive_c7;

	assign olim_c7 = pidf_pkg::MAG_W'(cfg.output_limit);
	assign osat_c7 = (oquot > olim_c7) ? cfg.output_limit : oquot[pidf_pkg::LIMIT_W-1:0];
	assign dpos_c7 = $signed({1'b0, osat_c7});

	always_comb begin
		if (cmd_s7 == pidf_pkg::CMD_CLEAR) begin
			drive_c7 = '0;
		end else if (sneg_s7) begin
			drive_c7 = -dpos_c7;
		end else begin
			drive_c7 = dpos_c7;
		end
	end

	// ------------------------------------------------------------------
	// Control state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q   <= '0;
			integrator_q <= '0;
			err_hold_q   <= '0;
			p_hold_q     <= '0;
			d_hold_q     <= '0;
		end else begin
			if (flow.fill[1] && cmd_s1 == pidf_pkg::CMD_RUN) begin
				last_err_q <= err_c1;
			end
			if (flow.fill[4]) begin
				integrator_q <= integ_next_c4;
				if (run_c4) begin
					err_hold_q <= err_s4;
					p_hold_q   <= p_s4;
					d_hold_q   <= d_s4;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers (no reset; valid bits live in u_flow)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (flow.fill[0]) begin
			cmd_s1  <= pidf_pkg::cmd_t'(cmd);
			sp_s1   <= set_point;
			meas_s1 <= measured;
		end
		if (flow.fill[1]) begin
			cmd_s2  <= cmd_s1;
			err_s2  <= err_c1;
			p_s2    <= p_full_c1[32:0];
			d_s2    <= d_full_c1[33:0];
			ff_s2   <= ff_full_c1[31:0];
			imag_s2 <= imag_c1;
			ineg_s2 <= err_c1[16];
		end
		if (flow.fill[2]) begin
			cmd_s3  <= cmd_s2;
			err_s3  <= err_s2;
			p_s3    <= p_s2;
			d_s3    <= dclamp_c2[31:0];
			ff_s3   <= ff_s2;
			ineg_s3 <= ineg_s2;
		end
		if (flow.fill[3]) begin
			cmd_s4 <= cmd_s3;
			err_s4 <= err_s3;
			p_s4   <= p_s3;
			d_s4   <= d_s3;
			ff_s4  <= ff_s3;
			inc_s4 <= inc_c3;
		end
		if (flow.fill[4]) begin
			cmd_s5 <= cmd_s4;
			err_s5 <= run_c4 ? err_s4 : err_hold_q;
			p_s5   <= run_c4 ? p_s4 : p_hold_q;
			d_s5   <= run_c4 ? d_s4 : d_hold_q;
			ff_s5  <= ff_s4;
		end
		if (flow.fill[5]) begin
			cmd_s6  <= cmd_s5;
			err_s6  <= err_s5;
			p_s6    <= p_s5;
			i_s6    <= integrator_q;
			d_s6    <= d_s5;
			smag_s6 <= sum_c5[34] ? sum_neg_c5[33:0] : sum_c5[33:0];
			sneg_s6 <= sum_c5[34];
		end
		if (flow.fill[6]) begin
			cmd_s7  <= cmd_s6;
			err_s7  <= err_s6;
			p_s7    <= p_s6;
			i_s7    <= i_s6;
			d_s7    <= d_s6;
			sneg_s7 <= sneg_s6;
		end
		if (flow.fill[7]) begin
			drive_s8 <= drive_c7;
			err_s8   <= err_s7;
			p_s8     <= p_s7;
			i_s8     <= i_s7;
			d_s8     <= d_s7;
		end
	end

	assign drive      = drive_s8;
	assign error_out  = err_s8;
	assign p_term_out = p_s8;
	assign i_term_out = i_s8;
	assign d_term_out = d_s8;

endmodule

// ===== design/pidf_regs.sv =====
// pidf_regs: configuration register file of the PIDF control step unit.
// Depends on pidf_pkg.
module pidf_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pidf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [pidf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pidf_pkg::cfg_t                   cfg
);

	pidf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// gains, windup limit and derivative limit zero, output limit at full scale
			cfg_q <= {{(4 * pidf_pkg::GAIN_W + 2 * pidf_pkg::LIMIT_W){1'b0}},
				{pidf_pkg::LIMIT_W{1'b1}}};
		end else if (cfg_valid) begin
			unique case (pidf_pkg::reg_idx_t'(cfg_index))
				pidf_pkg::REG_GAIN_P:       cfg_q.gain_p <= cfg_data[pidf_pkg::GAIN_W-1:0];
				pidf_pkg::REG_GAIN_I:       cfg_q.gain_i <= cfg_data[pidf_pkg::GAIN_W-1:0];
				pidf_pkg::REG_GAIN_D:       cfg_q.gain_d <= cfg_data[pidf_pkg::GAIN_W-1:0];
				pidf_pkg::REG_GAIN_FF:      cfg_q.gain_ff <= cfg_data[pidf_pkg::GAIN_W-1:0];
				pidf_pkg::REG_WINDUP_LIMIT: cfg_q.windup_limit <= cfg_data[pidf_pkg::LIMIT_W-1:0];
				pidf_pkg::REG_DERIV_LIMIT:  cfg_q.deriv_limit <= cfg_data[pidf_pkg::LIMIT_W-1:0];
				pidf_pkg::REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[pidf_pkg::LIMIT_W-1:0];
				default: begin
					// unused index: write dropped
				end
			endcase
		end
	end

endmodule

// ===== design/pidf_flow.sv =====
// pidf_flow: per-stage valid bits and load enables of the item pipeline.
// Depends on pidf_pkg.
module pidf_flow (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	output pidf_pkg::flow_t flow
);

	localparam int unsigned N = pidf_pkg::NSTAGE;

	logic [N-1:0] valid_q;
	logic [N-1:0] en;
	logic [N-1:0] upstream;

	// a stage can load when empty or when its item moves on
	assign en[N-1] = ~valid_q[N-1] | result_ready;
	for (genvar k = 0; k < N - 1; k++) begin : g_en
		assign en[k] = ~valid_q[k] | en[k+1];
	end

	assign upstream  = {valid_q[N-2:0], item_valid};
	assign flow.fill = en & upstream;

	assign item_ready   = en[0];
	assign result_valid = valid_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (en & upstream) | (~en & valid_q);
		end
	end

endmodule

// ===== design/pidf_cdiv.sv =====
// pidf_cdiv: unsigned divide by a constant as a reciprocal multiply, split in
// two partial products that are registered, then summed and shifted. Uses pidf_pkg.
module pidf_cdiv (
	input  logic                           clk,
	input  logic                           en,
	input  logic [pidf_pkg::MAG_W-1:0]     mag,
	input  logic [pidf_pkg::RECIP_W-1:0]   recip,
	input  logic [pidf_pkg::SHIFT_W-1:0]   shift,
	output logic [pidf_pkg::MAG_W-1:0]     quot
);

	localparam int unsigned HW = pidf_pkg::HALF_W;
	localparam int unsigned MW = pidf_pkg::MAG_W;

	logic [pidf_pkg::PP_W-1:0]   pp_hi_q;
	logic [pidf_pkg::PP_W-1:0]   pp_lo_q;
	logic [pidf_pkg::PROD_W-1:0] prod;
	logic [pidf_pkg::PROD_W-1:0] prod_sh;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_hi_q <= pidf_pkg::PP_W'(mag[MW-1:HW]) * pidf_pkg::PP_W'(recip);
			pp_lo_q <= pidf_pkg::PP_W'(mag[HW-1:0]) * pidf_pkg::PP_W'(recip);
		end
	end

	assign prod    = {pp_hi_q, HW'(0)} + pidf_pkg::PROD_W'(pp_lo_q);
	assign prod_sh = prod >> shift;
	assign quot    = prod_sh[MW-1:0];

endmodule
